// File: design/udf_pkg.sv
// Package with shared constants, codes and types of the unsigned decimal formatter.
`default_nettype none
package udf_pkg;

	localparam int MAX_WIDTH_DEF  = 63;
	localparam int VALUE_BITS_DEF = 64;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [2:0] LEN_INT   = 3'd0;
	localparam logic [2:0] LEN_LONG  = 3'd1;
	localparam logic [2:0] LEN_LLONG = 3'd2;
	localparam logic [2:0] LEN_SHORT = 3'd3;
	localparam logic [2:0] LEN_CHAR  = 3'd4;

	typedef struct packed {
		logic [5:0] width;
		logic [5:0] prec;
		logic       has_prec;
		logic       left;
		logic       zpad;
		logic       suppress;
	} udf_opts_t;

endpackage
`default_nettype wire

// File: design/unsigned_decimal_formatter.sv
// Top level: printf %u formatter with bit-serial BCD conversion and a character sequencer.
// The value is converted to BCD bit-serially, leading zero digits are then shifted out,
// and the sequencer places each character of the field in the output register.
// A new item is not taken while one is in flight: the next item is accepted once the last
// character of this one is in the output register.
// Reset clears the control state and the running character count to zero.
`default_nettype none
module unsigned_decimal_formatter import udf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [63:0]        value,
	input  logic [2:0]         length_mode,
	input  logic [5:0]         field_width,
	input  logic signed [6:0]  precision,
	input  logic               left_justify,
	input  logic               zero_pad,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               last,
	output logic [31:0]        total_printed
);

	localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int ND_W   = $clog2(DIGITS + 1);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_CONV = 3'b010,
		T_EMIT = 3'b100
	} top_state_t;

	top_state_t            state_q;
	udf_opts_t             opts_q;
	udf_opts_t             opts_in;
	logic [63:0]           trunc;
	logic [VALUE_BITS-1:0] val;
	logic                  accept;
	logic                  conv_done;
	logic [DIGITS*4-1:0]   conv_bcd;
	logic [ND_W-1:0]       conv_ndig;
	logic                  emit_start;
	logic                  emit_busy;

	always_comb begin
		unique case (length_mode)
			LEN_LONG, LEN_LLONG: trunc = value;
			LEN_SHORT:           trunc = {48'd0, value[15:0]};
			LEN_CHAR:            trunc = {56'd0, value[7:0]};
			default:             trunc = {32'd0, value[31:0]};
		endcase
	end

	assign val = trunc[VALUE_BITS-1:0];

	always_comb begin
		opts_in.width    = (field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : field_width;
		opts_in.has_prec = !precision[6];
		opts_in.prec     = (precision[5:0] > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : precision[5:0];
		opts_in.left     = left_justify;
		opts_in.zpad     = zero_pad;
		opts_in.suppress = !precision[6] && (precision[5:0] == 6'd0) && (val == '0);
	end

	assign in_ready   = (state_q == T_IDLE);
	assign accept     = in_valid && in_ready;
	assign emit_start = (state_q == T_CONV) && conv_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_CONV;
					end
				end
				T_CONV: begin
					if (conv_done) begin
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (!emit_busy) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opts_q <= opts_in;
		end
	end

	udf_bcd_conv #(
		.VALUE_BITS (VALUE_BITS),
		.DIGITS     (DIGITS)
	) u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.value  (val),
		.done   (conv_done),
		.bcd    (conv_bcd),
		.ndig   (conv_ndig)
	);

	udf_emit #(
		.DIGITS (DIGITS)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (emit_start),
		.opts          (opts_q),
		.bcd           (conv_bcd),
		.ndig          (conv_ndig),
		.busy          (emit_busy),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.last          (last),
		.total_printed (total_printed)
	);

endmodule
`default_nettype wire

// File: design/udf_bcd_conv.sv
// Bit-serial binary to BCD converter with leading-zero normalization.
`default_nettype none
module udf_bcd_conv import udf_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int DIGITS     = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [VALUE_BITS-1:0]        value,
	output logic                         done,
	output logic [DIGITS*4-1:0]          bcd,
	output logic [$clog2(DIGITS+1)-1:0]  ndig
);

	localparam int BCD_W = DIGITS * 4;
	localparam int ND_W  = $clog2(DIGITS + 1);
	localparam int CNT_W = $clog2(VALUE_BITS);

	typedef enum logic [2:0] {
		C_IDLE  = 3'b001,
		C_SHIFT = 3'b010,
		C_NORM  = 3'b100
	} conv_state_t;

	conv_state_t           state_q;
	logic [VALUE_BITS-1:0] shift_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      adj;
	logic [CNT_W-1:0]      cnt_q;
	logic [ND_W-1:0]       ndig_q;
	logic                  norm_stop;

	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d*4 +: 4] >= 4'd5) begin
				adj[d*4 +: 4] = bcd_q[d*4 +: 4] + 4'd3;
			end else begin
				adj[d*4 +: 4] = bcd_q[d*4 +: 4];
			end
		end
	end

	assign norm_stop = (bcd_q[BCD_W-1 -: 4] != 4'd0) || (ndig_q == ND_W'(1));
	assign done      = (state_q == C_NORM) && norm_stop;
	assign bcd       = bcd_q;
	assign ndig      = ndig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_SHIFT;
					end
				end
				C_SHIFT: begin
					if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
						state_q <= C_NORM;
					end
				end
				C_NORM: begin
					if (norm_stop) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			shift_q <= value;
			bcd_q   <= '0;
			cnt_q   <= '0;
		end else if (state_q == C_SHIFT) begin
			bcd_q   <= {adj[BCD_W-2:0], shift_q[VALUE_BITS-1]};
			shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
			cnt_q   <= cnt_q + CNT_W'(1);
			ndig_q  <= ND_W'(DIGITS);
		end else if (state_q == C_NORM && !norm_stop) begin
			bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
			ndig_q <= ndig_q - ND_W'(1);
		end
	end

endmodule
`default_nettype wire

// File: design/udf_emit.sv
// Character sequencer: padding, zero fill and digits into a registered output beat.
`default_nettype none
module udf_emit import udf_pkg::*; #(
	parameter int DIGITS = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  udf_opts_t                    opts,
	input  logic [DIGITS*4-1:0]          bcd,
	input  logic [$clog2(DIGITS+1)-1:0]  ndig,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [7:0]                   out_char,
	output logic                         last,
	output logic [31:0]                  total_printed
);

	localparam int BCD_W = DIGITS * 4;
	localparam int ND_W  = $clog2(DIGITS + 1);

	logic [BCD_W-1:0] dig_q;
	logic [ND_W-1:0]  dcnt_q;
	logic [6:0]       lpad_q;
	logic [6:0]       fill_q;
	logic [6:0]       rpad_q;
	logic [6:0]       rem_q;
	logic [7:0]       padch_q;
	logic             out_valid_q;
	logic [7:0]       out_char_q;
	logic             last_q;
	logic [31:0]      total_q;

	logic [6:0]       nd7;
	logic [6:0]       prec7;
	logic [6:0]       width7;
	logic [6:0]       body;
	logic [6:0]       fill;
	logic [6:0]       pad;
	logic             adv;
	logic [7:0]       ch;

	always_comb begin
		nd7    = opts.suppress ? 7'd0 : 7'(ndig);
		prec7  = opts.has_prec ? {1'b0, opts.prec} : 7'd0;
		width7 = {1'b0, opts.width};
		body   = (prec7 > nd7) ? prec7 : nd7;
		fill   = (prec7 > nd7) ? (prec7 - nd7) : 7'd0;
		pad    = (width7 > body) ? (width7 - body) : 7'd0;
	end

	assign busy = (rem_q != 7'd0);
	assign adv  = busy && (!out_valid_q || out_ready);

	always_comb begin
		if (lpad_q != 7'd0) begin
			ch = padch_q;
		end else if (fill_q != 7'd0) begin
			ch = CHAR_ZERO;
		end else if (dcnt_q != '0) begin
			ch = CHAR_ZERO | {4'd0, dig_q[BCD_W-1 -: 4]};
		end else begin
			ch = CHAR_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (start) begin
				rem_q <= pad + body;
			end else if (adv) begin
				rem_q <= rem_q - 7'd1;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				total_q     <= total_q + 32'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dig_q   <= bcd;
			dcnt_q  <= opts.suppress ? '0 : ndig;
			fill_q  <= fill;
			lpad_q  <= opts.left ? 7'd0 : pad;
			rpad_q  <= opts.left ? pad : 7'd0;
			padch_q <= (opts.zpad && !opts.has_prec && !opts.left) ? CHAR_ZERO : CHAR_SPACE;
		end else if (adv) begin
			if (lpad_q != 7'd0) begin
				lpad_q <= lpad_q - 7'd1;
			end else if (fill_q != 7'd0) begin
				fill_q <= fill_q - 7'd1;
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - ND_W'(1);
				dig_q  <= {dig_q[BCD_W-5:0], 4'd0};
			end else begin
				rpad_q <= rpad_q - 7'd1;
			end
		end
		if (adv) begin
			out_char_q <= ch;
			last_q     <= (rem_q == 7'd1);
		end
	end

	assign out_valid     = out_valid_q;
	assign out_char      = out_char_q;
	assign last          = last_q;
	assign total_printed = total_q;

endmodule
`default_nettype wire
